// File: design/pts_pkg.sv
`default_nettype none

package pts_pkg;

    localparam int TASK_SLOTS_DEFAULT = 8;
    localparam int MAX_RESULTS        = 8;
    localparam int INDEX_W            = 8;
    localparam int VALUE_W            = 32;
    localparam int DUE_TASK_W         = 3;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUSPEND = 3'd2,
        OP_RESUME  = 3'd3,
        OP_DELETE  = 3'd4,
        OP_SLEEP   = 3'd5,
        OP_WAKE    = 3'd6,
        OP_SCAN    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_SLEEP = 2'd1,
        ST_NOT_USED   = 2'd2,
        ST_BAD_INDEX  = 2'd3
    } status_t;

    // One classified command as it waits between the front and the back.
    typedef struct packed {
        op_t                op;
        logic               bad_index;
        logic               zero_len;
        logic [INDEX_W-1:0] task_index;
        logic [VALUE_W-1:0] operand_value;
    } cmd_t;

    typedef struct packed {
        status_t               status;
        logic                  due;
        logic [DUE_TASK_W-1:0] due_task;
        logic                  last;
    } result_t;

endpackage

`default_nettype wire

// File: design/pts_front.sv
`default_nettype none

module pts_front
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire op_t                in_op,
    input  wire logic [INDEX_W-1:0] in_index,
    input  wire logic [VALUE_W-1:0] in_value,
    output logic                    cmd_valid,
    input  wire logic               cmd_pop,
    output cmd_t                    cmd
);

    // Two-entry queue decouples the classifier from the executor.
    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    cmd_t       classified;

    always_comb
    begin
        classified.op            = in_op;
        classified.bad_index     = (in_op != OP_TICK) && (in_op != OP_SCAN) &&
                                   (in_index >= INDEX_W'(TASK_SLOTS));
        classified.zero_len      = (in_value == '0);
        classified.task_index    = in_index;
        classified.operand_value = in_value;
    end

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_pop && cmd_valid)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push, cmd_pop && cmd_valid})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= classified;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue fill count went past its depth");

endmodule

`default_nettype wire

// File: design/pts_back.sv
`default_nettype none

module pts_back
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_pop,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_ready,
    output result_t   res
);

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_W-1:0]      tick_reg, tick_next;
    logic [TASK_SLOTS-1:0]   used_reg, used_next;
    logic [TASK_SLOTS-1:0]   running_reg, running_next;
    logic [TASK_SLOTS-1:0]   sleeping_reg, sleeping_next;
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    held_reg, held_next;
    logic [SLOT_W-1:0]       held_task_reg, held_task_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_data_reg, out_data_next;

    // Per-slot words live in single-port-read memories; used flags gate every use of the read data.
    logic [VALUE_W-1:0] period_mem   [TASK_SLOTS];
    logic [VALUE_W-1:0] last_run_mem [TASK_SLOTS];
    logic [VALUE_W-1:0] sleep_mem    [TASK_SLOTS];
    logic [VALUE_W-1:0] rd_period_reg, rd_last_reg, rd_sleep_reg;

    logic               per_we, lr_we, sl_we;
    logic [SLOT_W-1:0]  wr_addr, rd_addr, idx_step;
    logic [VALUE_W-1:0] per_wdata, lr_wdata, sl_wdata;

    logic               out_free, emit;
    result_t            emit_res;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] elapsed;
    logic               active, wake, awake, slot_due, advance;
    logic [SLOT_W+2:0]  held_ext;

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;
    assign slot      = cmd.task_index[SLOT_W-1:0];
    assign idx_step  = (idx_reg == LAST_SLOT) ? idx_reg : idx_reg + SLOT_W'(1);
    assign held_ext  = {3'b000, held_task_reg};

    // Slot evaluation for the current scan position.
    assign elapsed  = tick_reg - rd_last_reg;
    assign active   = used_reg[idx_reg] && running_reg[idx_reg];
    assign wake     = active && sleeping_reg[idx_reg] && (elapsed >= rd_sleep_reg);
    assign awake    = !sleeping_reg[idx_reg] || wake;
    assign slot_due = active && awake && (elapsed >= rd_period_reg);
    assign advance  = !(slot_due && held_reg && !out_free);

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        used_next      = used_reg;
        running_next   = running_reg;
        sleeping_next  = sleeping_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        held_next      = held_reg;
        held_task_next = held_task_reg;
        cmd_pop        = 1'b0;
        emit           = 1'b0;
        emit_res       = '0;
        per_we         = 1'b0;
        lr_we          = 1'b0;
        sl_we          = 1'b0;
        wr_addr        = slot;
        per_wdata      = cmd.operand_value;
        lr_wdata       = tick_reg;
        sl_wdata       = cmd.operand_value;
        rd_addr        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && (cmd.op == OP_SCAN))
                begin
                    cmd_pop    = 1'b1;
                    state_next = S_SCAN;
                    idx_next   = '0;
                    cnt_next   = '0;
                    held_next  = 1'b0;
                end
                else if (cmd_valid && out_free)
                begin
                    cmd_pop         = 1'b1;
                    emit            = 1'b1;
                    emit_res.status = ST_OK;
                    emit_res.last   = 1'b1;
                    if (cmd.op == OP_TICK)
                    begin
                        tick_next = tick_reg + VALUE_W'(1);
                    end
                    else if (cmd.bad_index)
                    begin
                        emit_res.status = ST_BAD_INDEX;
                    end
                    else
                    begin
                        case (cmd.op)
                            OP_ADD:
                            begin
                                per_we              = 1'b1;
                                lr_we               = 1'b1;
                                lr_wdata            = '0;
                                used_next[slot]     = 1'b1;
                                running_next[slot]  = 1'b1;
                                sleeping_next[slot] = 1'b0;
                            end
                            OP_SUSPEND, OP_RESUME:
                            begin
                                if (!used_reg[slot])
                                begin
                                    emit_res.status = ST_NOT_USED;
                                end
                                else
                                begin
                                    running_next[slot] = (cmd.op == OP_RESUME);
                                end
                            end
                            OP_DELETE:
                            begin
                                used_next[slot]     = 1'b0;
                                running_next[slot]  = 1'b0;
                                sleeping_next[slot] = 1'b0;
                            end
                            OP_SLEEP:
                            begin
                                if (cmd.zero_len)
                                begin
                                    emit_res.status = ST_ZERO_SLEEP;
                                end
                                else if (!used_reg[slot])
                                begin
                                    emit_res.status = ST_NOT_USED;
                                end
                                else
                                begin
                                    sl_we               = 1'b1;
                                    lr_we               = 1'b1;
                                    sleeping_next[slot] = 1'b1;
                                end
                            end
                            OP_WAKE:
                            begin
                                if (!used_reg[slot])
                                begin
                                    emit_res.status = ST_NOT_USED;
                                end
                                else
                                begin
                                    sleeping_next[slot] = 1'b0;
                                end
                            end
                            default:
                            begin
                                emit_res.status = ST_OK;
                            end
                        endcase
                    end
                end
            end

            S_SCAN:
            begin
                rd_addr = advance ? idx_step : idx_reg;
                wr_addr = idx_reg;
                if (advance)
                begin
                    if (wake)
                    begin
                        sleeping_next[idx_reg] = 1'b0;
                    end
                    if (slot_due)
                    begin
                        lr_we          = 1'b1;
                        held_next      = 1'b1;
                        held_task_next = idx_reg;
                        cnt_next       = cnt_reg + CNT_W'(1);
                        if (held_reg)
                        begin
                            // A later hit proves the held one is not the final result.
                            emit              = 1'b1;
                            emit_res.status   = ST_OK;
                            emit_res.due      = 1'b1;
                            emit_res.due_task = held_ext[DUE_TASK_W-1:0];
                            emit_res.last     = 1'b0;
                        end
                    end
                    if ((idx_reg == LAST_SLOT) || (cnt_next == CNT_W'(MAX_RESULTS)))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_step;
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    emit_res.status = ST_OK;
                    emit_res.last   = 1'b1;
                    if (held_reg)
                    begin
                        emit_res.due      = 1'b1;
                        emit_res.due_task = held_ext[DUE_TASK_W-1:0];
                    end
                    held_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_res;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            used_reg      <= '0;
            running_reg   <= '0;
            sleeping_reg  <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            held_reg      <= 1'b0;
            held_task_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            used_reg      <= used_next;
            running_reg   <= running_next;
            sleeping_reg  <= sleeping_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            held_reg      <= held_next;
            held_task_reg <= held_task_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (per_we)
        begin
            period_mem[wr_addr] <= per_wdata;
        end
        if (lr_we)
        begin
            last_run_mem[wr_addr] <= lr_wdata;
        end
        if (sl_we)
        begin
            sleep_mem[wr_addr] <= sl_wdata;
        end
        rd_period_reg <= period_mem[rd_addr];
        rd_last_reg   <= last_run_mem[rd_addr];
        rd_sleep_reg  <= sleep_mem[rd_addr];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("scan reported more tasks than allowed");

    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> (cnt_reg != '0))
        else $error("held result without a counted hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || res_ready))
        else $error("result register overwritten while still pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == S_IDLE))
        else $error("command taken while a scan is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> (state_reg == S_SCAN) || (state_reg == S_FINISH))
        else $error("scan left without its closing result");

endmodule

`default_nettype wire

// File: design/periodic_task_scheduler_core.sv
// For a control operation or tick, the transaction is registered in the queue and its
// result then in the output register, where m_tvalid rises; a scan or a stalled output can delay it.
// A scan holds the executor while it walks the slots (one slot per cycle through
// the single read port of the slot memories) and while it waits on a stalled output.
// Input transactions are taken every cycle while the two-entry queue has room.
// Reset clears the tick counter, all slot flags, the queue and the output register;
// the slot period, last-run and sleep memories are not cleared and are used only for used slots.
`default_nettype none

module periodic_task_scheduler_core
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [7:0] task_index, [39:8] operand_value
    input  wire logic [2:0]  s_tuser,   // [2:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [1:0] status, [4:2] due_task, [7:5] zero
    output logic             m_tuser,   // [0] due
    output logic             m_tlast
);

    // The front classifies each incoming transaction (range check on the slot
    // index, zero sleep length) and queues it; the back owns all task state.
    logic    cmd_valid;
    logic    cmd_pop;
    cmd_t    cmd;
    result_t res;

    pts_front #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser)),
        .in_index  (s_tdata[7:0]),
        .in_value  (s_tdata[39:8]),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // The back runs control operations straight from its idle state and walks the slots in
    // index order for a scan. A due task is held back one hit so that the
    // final result of the scan can carry tlast.
    pts_back #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {3'b000, res.due_task, res.status};
    assign m_tuser = res.due;
    assign m_tlast = res.last;

endmodule

`default_nettype wire
